// File: rtl/core/rlb_pkg.sv
// Shared types and constants for the RGB layer blend unit.
package rlb_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int NUM_CH     = 3;
  localparam int PROD_W     = 2 * PIX_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int QUO_W      = PIX_W + 1;

  typedef logic [PIX_W-1:0] pix_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CHANNEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_AMOUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR   = 3'd3;

  typedef enum logic [2:0] {
    MODE_MULTIPLY = 3'd0,
    MODE_SCREEN   = 3'd1,
    MODE_SUBTRACT = 3'd2,
    MODE_OVERLAY  = 3'd3,
    MODE_ADD      = 3'd4,
    MODE_SCALE    = 3'd5
  } blend_mode_t;

  // Per-channel operation carried down the pipe.
  typedef enum logic [1:0] {
    OP_PASS   = 2'd0,
    OP_DIV    = 2'd1,
    OP_ADDSAT = 2'd2,
    OP_MULSAT = 2'd3
  } chan_kind_t;

  typedef struct packed {
    chan_kind_t kind;
    pix_t       x;
    pix_t       y;
    logic       dbl;
    logic       inv;
  } chan_op_t;

  typedef struct packed {
    chan_kind_t         kind;
    logic [PROD_W-1:0]  val;
    logic               dbl;
    logic               inv;
  } chan_mid_t;

  typedef struct packed {
    logic              is_div;
    logic [NUM_W-1:0]  num;
    logic [QUO_W-1:0]  quo;
    logic              inv;
    pix_t              res;
  } chan_div_t;

endpackage

// File: rtl/core/rlb_if.sv
// Valid/ready channel interfaces for pixel pairs in and blended pixels out.
interface rlb_in_if;
  import rlb_pkg::*;
  logic valid;
  logic ready;
  pix_t top_red;
  pix_t top_green;
  pix_t top_blue;
  pix_t bottom_red;
  pix_t bottom_green;
  pix_t bottom_blue;

  modport source (output valid, top_red, top_green, top_blue,
                  bottom_red, bottom_green, bottom_blue, input ready);
  modport sink   (input valid, top_red, top_green, top_blue,
                  bottom_red, bottom_green, bottom_blue, output ready);
endinterface

interface rlb_out_if;
  import rlb_pkg::*;
  logic valid;
  logic ready;
  pix_t out_red;
  pix_t out_green;
  pix_t out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

// File: rtl/core/rgb_layer_blend_unit.sv
// Top level: four-stage pipelined RGB layer blender with config registers.
// Throughput: one pixel pair per cycle; each stage holds when the next is full.
// Stages: operand select, 8x8 multiply or add, reciprocal divide by 255 or saturate, correction.
// Reset (synchronous, rst_n low): pipeline emptied, blend_mode 0 (multiply),
// target_channel 0, add_amount 0, scale_factor 1.
module rgb_layer_blend_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  rlb_in_if.sink                        in_ch,
  rlb_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rlb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlb_pkg::*;

  blend_mode_t mode_r;
  logic [1:0]  chan_r;
  pix_t        add_r;
  pix_t        scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_MULTIPLY;
      chan_r  <= 2'd0;
      add_r   <= '0;
      scale_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLEND_MODE:     mode_r  <= blend_mode_t'(cfg_data[2:0]);
        CFG_TARGET_CHANNEL: chan_r  <= cfg_data[1:0];
        CFG_ADD_AMOUNT:     add_r   <= cfg_data;
        CFG_SCALE_FACTOR:   scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage takes new data when it is empty or drains.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: pick operands per channel.
  pix_t     top_px [NUM_CH];
  pix_t     bot_px [NUM_CH];
  chan_op_t s1_nxt [NUM_CH];
  chan_op_t s1_r   [NUM_CH];

  assign top_px[0] = in_ch.top_red;
  assign top_px[1] = in_ch.top_green;
  assign top_px[2] = in_ch.top_blue;
  assign bot_px[0] = in_ch.bottom_red;
  assign bot_px[1] = in_ch.bottom_green;
  assign bot_px[2] = in_ch.bottom_blue;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s1_nxt[c].kind = OP_PASS;
      s1_nxt[c].x    = top_px[c];
      s1_nxt[c].y    = bot_px[c];
      s1_nxt[c].dbl  = 1'b0;
      s1_nxt[c].inv  = 1'b0;
      unique case (mode_r)
        MODE_MULTIPLY: begin
          s1_nxt[c].kind = OP_DIV;
        end
        MODE_SCREEN: begin
          s1_nxt[c].kind = OP_DIV;
          s1_nxt[c].x    = ~top_px[c];
          s1_nxt[c].y    = ~bot_px[c];
          s1_nxt[c].inv  = 1'b1;
        end
        MODE_SUBTRACT: begin
          s1_nxt[c].x = (bot_px[c] > top_px[c]) ? bot_px[c] - top_px[c] : '0;
        end
        MODE_OVERLAY: begin
          s1_nxt[c].kind = OP_DIV;
          s1_nxt[c].dbl  = 1'b1;
          if (bot_px[c][PIX_W-1]) begin
            s1_nxt[c].x   = ~top_px[c];
            s1_nxt[c].y   = ~bot_px[c];
            s1_nxt[c].inv = 1'b1;
          end
        end
        MODE_ADD: begin
          if (chan_r == 2'(c)) begin
            s1_nxt[c].kind = OP_ADDSAT;
            s1_nxt[c].y    = add_r;
          end
        end
        MODE_SCALE: begin
          if (chan_r == 2'(c)) begin
            s1_nxt[c].kind = OP_MULSAT;
            s1_nxt[c].y    = scale_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Stage 2: multiply or add.
  chan_mid_t s2_nxt [NUM_CH];
  chan_mid_t s2_r   [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s2_nxt[c].kind = s1_r[c].kind;
      s2_nxt[c].dbl  = s1_r[c].dbl;
      s2_nxt[c].inv  = s1_r[c].inv;
      case (s1_r[c].kind)
        OP_DIV, OP_MULSAT: s2_nxt[c].val = s1_r[c].x * s1_r[c].y;
        OP_ADDSAT:         s2_nxt[c].val = PROD_W'(s1_r[c].x) + PROD_W'(s1_r[c].y);
        default:           s2_nxt[c].val = PROD_W'(s1_r[c].x);
      endcase
    end
  end

  // Stage 3: estimate quotient by 255 with a 257/65536 reciprocal, or saturate.
  chan_div_t        s3_nxt [NUM_CH];
  chan_div_t        s3_r   [NUM_CH];
  logic [NUM_W-1:0] num    [NUM_CH];
  logic [NUM_W+7:0] recip  [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      num[c] = (s2_r[c].dbl ? {s2_r[c].val, 1'b0} : {1'b0, s2_r[c].val})
               + NUM_W'(127);
      recip[c] = {num[c], 8'd0} + (NUM_W + 8)'(num[c]);
      s3_nxt[c].is_div = (s2_r[c].kind == OP_DIV);
      s3_nxt[c].num    = num[c];
      s3_nxt[c].quo    = recip[c][NUM_W+7:16];
      s3_nxt[c].inv    = s2_r[c].inv;
      if (s2_r[c].val > PROD_W'(255)) begin
        s3_nxt[c].res = 8'hFF;
      end else begin
        s3_nxt[c].res = s2_r[c].val[PIX_W-1:0];
      end
    end
  end

  // Stage 4: estimate is low by at most one; fix it and mirror if needed.
  pix_t               s4_nxt [NUM_CH];
  pix_t               s4_r   [NUM_CH];
  logic [NUM_W:0]     rem    [NUM_CH];
  logic [QUO_W-1:0]   quo    [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rem[c] = {1'b0, s3_r[c].num} - {s3_r[c].quo, 8'd0}
               + (NUM_W + 1)'(s3_r[c].quo);
      quo[c] = (rem[c] >= (NUM_W + 1)'(255)) ? s3_r[c].quo + QUO_W'(1) : s3_r[c].quo;
      if (s3_r[c].is_div) begin
        s4_nxt[c] = s3_r[c].inv ? ~quo[c][PIX_W-1:0] : quo[c][PIX_W-1:0];
      end else begin
        s4_nxt[c] = s3_r[c].res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
    if (rdy4) s4_r <= s4_nxt;
  end

  assign out_ch.valid     = v4_r;
  assign out_ch.out_red   = s4_r[0];
  assign out_ch.out_green = s4_r[1];
  assign out_ch.out_blue  = s4_r[2];

endmodule

// File: rtl/core/rlb_checker.sv
// Port-level checks for the RGB layer blend unit, bound to the top level.
module rlb_checker (
  input logic       clk,
  input logic       rst_n,
  rlb_in_if.sink    in_ch,
  rlb_out_if.source out_ch
);

  // Hold a result beat until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid &&
      $stable(out_ch.out_red) && $stable(out_ch.out_green) && $stable(out_ch.out_blue))
    else $error("result beat dropped or changed while stalled");

  // An empty pipe after reset shows no result.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // A ready sink never blocks the input side.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while result side is ready");

  // An accepted beat comes out as a result beat when the sink keeps up.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready)
      |=> out_ch.valid)
    else $error("result beat missing after pipeline latency");

endmodule

bind rgb_layer_blend_unit rlb_checker u_rlb_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
